FILE: sv/stki_pkg.sv
// ----------------------------------------------------------------------------
// Sorted time-key index: shared package
// Types, codes and defaults used by the index controller and its result
// register.
// ----------------------------------------------------------------------------
package stki_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int MAX_RUN_DEF  = 64;

  localparam int KEY_W    = 64;
  localparam int LIMIT_W  = 7;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  // Slave word: time_key, entry_id, range_end, range_limit, padded to bytes.
  localparam int S_TDATA_W = 200;
  // Master word: found_id, stored_count, padded to bytes.
  localparam int M_TDATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] time_key;
    logic [KEY_W-1:0] entry_id;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_id;
    logic [COUNT_W-1:0]  stored_count;
    logic                last_of_run;
  } result_t;

  // Order is time first, then id, both unsigned.
  function automatic logic key_below(entry_t a, entry_t b);
    logic below;
    if (a.time_key != b.time_key) begin
      below = a.time_key < b.time_key;
    end else begin
      below = a.entry_id < b.entry_id;
    end
    return below;
  endfunction

endpackage

FILE: sv/sorted_time_key_index.sv
// ----------------------------------------------------------------------------
// Sorted time-key index
// Table of (time, id) pairs kept sorted in one RAM, with add, remove and
// range query commands.
// ----------------------------------------------------------------------------
// The table lives in a single RAM with one write and one registered read
// port, and the block works on one command at a time. Every add, remove or
// query, but an add on a full table, starts with a binary search in which
// each probe reads the middle entry in S_SRCH and compares it in S_SRCH_CMP.
// An add then moves each entry above the insert point up by one, and a
// remove moves each entry above the hit down by one, at one entry per cycle
// because the move reads one address while writing the previous one. A
// range query reads each entry in S_SCAN_RD and compares it in S_SCAN_CMP,
// where it waits while the result register is not free. A new command is
// taken once the previous one has handed its last word to the result
// register.
// ----------------------------------------------------------------------------
module sorted_time_key_index
  import stki_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_RUN  = MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // time_key [63:0], entry_id [127:64], range_end [191:128],
  // range_limit [198:192], zero pad [199]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // command [1:0]
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // found_id [63:0], stored_count [72:64], zero pad [79:73]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0]      CAP_C = CW'(CAPACITY);
  localparam logic [LIMIT_W-1:0] RUN_C = LIMIT_W'(MAX_RUN);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SRCH     = 10'b00_0000_0010,
    S_SRCH_CMP = 10'b00_0000_0100,
    S_CHECK    = 10'b00_0000_1000,
    S_MOVE     = 10'b00_0001_0000,
    S_INSERT   = 10'b00_0010_0000,
    S_SCAN_RD  = 10'b00_0100_0000,
    S_SCAN_CMP = 10'b00_1000_0000,
    S_SCAN_END = 10'b01_0000_0000,
    S_RESULT   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]    cmd;
  entry_t              key;
  logic [KEY_W-1:0]    rend;
  logic [LIMIT_W-1:0]  lim;
  logic [CW-1:0]       count;
  logic [CW-1:0]       lo, hi, mid_calc;
  logic [AW-1:0]       mid;
  logic [AW-1:0]       rd_ptr, wr_addr;
  logic [CW-1:0]       left;
  logic                pend;
  logic [CW-1:0]       scan_i;
  logic [LIMIT_W-1:0]  n;
  logic                have;
  logic [KEY_W-1:0]    held_id;
  logic [STATUS_W-1:0] res_status;

  logic                accept;
  logic [CMD_W-1:0]    in_cmd;
  logic [LIMIT_W-1:0]  in_lim;
  logic                full;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  logic                out_load, out_free;
  result_t             out_res;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = s_axis_tuser;
  assign in_lim        = s_axis_tdata[198:192];
  assign full          = (count >= CAP_C);
  assign mid_calc      = lo + ((hi - lo) >> 1);

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = mid_calc[AW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = wr_addr;
    ram_wdata  = ram_rdata;
    out_load   = 1'b0;
    out_res    = '{status: res_status, found_id: '0,
                   stored_count: COUNT_W'(count), last_of_run: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ADD && full) begin
            state_next = S_RESULT;
          end else if (in_cmd == CMD_ADD || in_cmd == CMD_REMOVE ||
                       in_cmd == CMD_QUERY) begin
            state_next = S_SRCH;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SRCH: begin
        if (lo < hi) begin
          ram_re     = 1'b1;
          state_next = S_SRCH_CMP;
        end else if (cmd == CMD_ADD) begin
          state_next = S_MOVE;
        end else if (cmd == CMD_REMOVE) begin
          if (lo < count) begin
            ram_re     = 1'b1;
            ram_raddr  = lo[AW-1:0];
            state_next = S_CHECK;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SRCH_CMP: begin
        state_next = S_SRCH;
      end
      S_CHECK: begin
        state_next = (ram_rdata == key) ? S_MOVE : S_RESULT;
      end
      S_MOVE: begin
        // Write the entry read last cycle while reading the next one.
        ram_we = pend;
        if (left != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr;
        end else begin
          state_next = (cmd == CMD_ADD) ? S_INSERT : S_RESULT;
        end
      end
      S_INSERT: begin
        ram_we     = 1'b1;
        ram_waddr  = lo[AW-1:0];
        ram_wdata  = key;
        state_next = S_RESULT;
      end
      S_SCAN_RD: begin
        if (scan_i < count && n < lim) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_i[AW-1:0];
          state_next = S_SCAN_CMP;
        end else begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_CMP: begin
        // One id is held back until the next entry shows whether it ends the run.
        if (ram_rdata.time_key > rend) begin
          state_next = S_SCAN_END;
        end else if (!have) begin
          state_next = S_SCAN_RD;
        end else if (out_free) begin
          out_load            = 1'b1;
          out_res.status      = ST_ENTRY;
          out_res.found_id    = held_id;
          out_res.last_of_run = 1'b0;
          state_next          = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_res.status   = have ? ST_ENTRY : ST_EMPTY;
          out_res.found_id = have ? held_id : '0;
          state_next       = S_IDLE;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      have  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd          <= in_cmd;
            key.time_key <= s_axis_tdata[63:0];
            key.entry_id <= (in_cmd == CMD_QUERY) ? '0 : s_axis_tdata[127:64];
            rend         <= s_axis_tdata[191:128];
            lim          <= (in_lim == '0 || in_lim > RUN_C) ? RUN_C : in_lim;
            lo           <= '0;
            hi           <= count;
            res_status   <= (in_cmd == CMD_ADD && full) ? ST_FULL : ST_DONE;
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid <= mid_calc[AW-1:0];
          end else if (cmd == CMD_ADD) begin
            left   <= count - lo;
            rd_ptr <= AW'(count - CW'(1));
            pend   <= 1'b0;
          end else if (cmd == CMD_REMOVE) begin
            if (lo >= count) begin
              res_status <= ST_ABSENT;
            end
          end else begin
            scan_i <= lo;
            n      <= '0;
            have   <= 1'b0;
          end
        end
        S_SRCH_CMP: begin
          if (key_below(ram_rdata, key)) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
        end
        S_CHECK: begin
          if (ram_rdata == key) begin
            left   <= count - lo - CW'(1);
            rd_ptr <= AW'(lo + CW'(1));
            pend   <= 1'b0;
          end else begin
            res_status <= ST_ABSENT;
          end
        end
        S_MOVE: begin
          pend <= (left != '0);
          if (left != '0) begin
            left <= left - CW'(1);
            if (cmd == CMD_ADD) begin
              wr_addr <= rd_ptr + AW'(1);
              rd_ptr  <= rd_ptr - AW'(1);
            end else begin
              wr_addr <= rd_ptr - AW'(1);
              rd_ptr  <= rd_ptr + AW'(1);
            end
          end else if (cmd == CMD_REMOVE) begin
            count <= count - CW'(1);
          end
        end
        S_INSERT: begin
          count <= count + CW'(1);
        end
        S_SCAN_CMP: begin
          if (ram_rdata.time_key <= rend && (!have || out_free)) begin
            held_id <= ram_rdata.entry_id;
            have    <= 1'b1;
            n       <= n + LIMIT_W'(1);
            scan_i  <= scan_i + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  stki_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  stki_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .res          (out_res),
    .free         (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_move_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_ADD && count == CAP_C) |=>
      (state == S_RESULT && res_status == ST_FULL))
    else $error("add on a full table not rejected");

  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP) |-> (n < lim))
    else $error("query run beyond its limit");

endmodule

FILE: sv/stki_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module stki_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/stki_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result word toward the master side so the controller can move
// on while the word waits to be taken.
// ----------------------------------------------------------------------------
module stki_out_reg
  import stki_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              res,
  output logic                 free,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // found_id [63:0], stored_count [72:64], zero pad [79:73]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast
);

  result_t held;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - KEY_W - COUNT_W)'(0), held.stored_count, held.found_id};
  assign m_axis_tuser = held.status;
  assign m_axis_tlast = held.last_of_run;

endmodule
